FILE: hdl/pls_pkg.sv
// Shared types and codes for the positional list store.
`default_nettype none

package pls_pkg;

  // Request codes carried in the func field
  typedef enum logic [3:0] {
    FN_INS_HEAD = 4'd0,
    FN_INS_TAIL = 4'd1,
    FN_INS_POS  = 4'd2,
    FN_DEL_HEAD = 4'd3,
    FN_DEL_TAIL = 4'd4,
    FN_DEL_POS  = 4'd5,
    FN_COUNT    = 4'd6,
    FN_SET      = 4'd7,
    FN_GET      = 4'd8,
    FN_FIND     = 4'd9
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_POS   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // What every cell does with its entry in the accept cycle
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_INS   = 2'd1,
    CELL_DEL   = 2'd2,
    CELL_WRITE = 2'd3
  } cell_op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] value;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         match_count;
    logic [7:0]         length;
  } rsp_t;

  // Broadcast update command for the cell row
  typedef struct packed {
    cell_op_t   op;
    logic [7:0] idx;
  } cell_ctl_t;

  // Query wave passed from cell to cell
  typedef struct packed {
    logic        valid;
    logic [7:0]  cnt;
    logic [7:0]  fpos;
    logic [31:0] rd;
  } wave_t;

endpackage

`default_nettype wire

FILE: hdl/pls_cell.sv
// One storage cell of the list row: entry register plus one query wave stage.
`default_nettype none

module pls_cell import pls_pkg::*; #(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cell_ctl_t             ctl,
  input  wire logic [DATA_WIDTH-1:0] wr_value,
  input  wire logic [DATA_WIDTH-1:0] left,
  input  wire logic [DATA_WIDTH-1:0] right,
  output logic      [DATA_WIDTH-1:0] entry,
  input  wire logic [7:0]            count,
  input  wire logic [DATA_WIDTH-1:0] qval,
  input  wire logic [7:0]            qidx,
  input  wire wave_t                 wave_in,
  output wave_t                      wave_out
);

  localparam logic [7:0] MY_IDX = 8'(IDX);
  localparam logic [7:0] MY_POS = 8'(IDX + 1);

  logic [DATA_WIDTH-1:0] entry_next;
  logic                  live;
  logic                  hit;
  logic                  w_valid;
  logic [7:0]            w_cnt;
  logic [7:0]            w_fpos;
  logic [31:0]           w_rd;

  // Shift towards the tail on insert, close the gap on delete
  always_comb begin
    entry_next = entry;
    case (ctl.op)
      CELL_INS: begin
        if (MY_IDX > ctl.idx) begin
          entry_next = left;
        end else if (MY_IDX == ctl.idx) begin
          entry_next = wr_value;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= ctl.idx) begin
          entry_next = right;
        end
      end
      CELL_WRITE: begin
        if (MY_IDX == ctl.idx) begin
          entry_next = wr_value;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign live = (MY_IDX < count);
  assign hit  = live && (entry == qval);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else begin
      w_valid <= wave_in.valid;
    end
  end

  // Accumulate the match count, keep the first hit, pick up the addressed entry
  always_ff @(posedge clk) begin
    w_cnt  <= wave_in.cnt + 8'(hit);
    w_fpos <= (wave_in.fpos == 8'd0 && hit) ? MY_POS : wave_in.fpos;
    w_rd   <= (MY_IDX == qidx) ? 32'(entry) : wave_in.rd;
  end

  always_comb begin
    wave_out.valid = w_valid;
    wave_out.cnt   = w_cnt;
    wave_out.fpos  = w_fpos;
    wave_out.rd    = w_rd;
  end

endmodule

`default_nettype wire

FILE: hdl/positional_list_store.sv
// Top level of the positional list store: request decode, cell row and result buffering.
//
// Use: an ordered list of up to DEPTH values addressed by 1-based position.
// The req channel takes one request word (func, value, position) on a rising edge
// with req_valid high and req_stall low; the rsp channel gives one result word
// (status, read_value, found_position, match_count, length) per request, taken on
// an edge with rsp_valid high and rsp_stall low.
// Every entry lives in its own cell of a row; inserts and deletes shift the whole
// row by one place in the accept cycle, so updates, set and all error cases give their
// word through the output register and the next request may follow at once.
// Count, find and a valid get send a query wave down the row, one cell per cycle:
// the result passes the launch register, every cell and the output register, while
// the request channel stalls. This wave through the row sets the rate of those requests.
// A two-word result buffer (output register plus a holding register) lets one more
// request be accepted while the receiver stalls; after that req_stall rises until
// the held word moves on.
// Reset empties the list (length 0) and drops any pending result; entry contents
// are not cleared and are never visible before being written.
`default_nettype none

module positional_list_store import pls_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t                state, state_next;
  logic [CW-1:0]         cnt, cnt_next;
  logic                  acc;
  logic                  is_scan;
  logic                  launch;
  logic [DATA_WIDTH-1:0] wr_value;
  logic [DATA_WIDTH-1:0] qval;
  logic [7:0]            qidx;
  logic [3:0]            qfunc;
  logic [7:0]            cnt8;
  logic [8:0]            cnt9;
  logic                  full;
  logic                  empty;
  logic                  pos_ok;
  logic                  pos_ok_ins;
  logic [7:0]            pos_idx;
  cell_ctl_t             ctl;
  rsp_t                  imm_res;
  rsp_t                  scan_res;
  rsp_t                  res;
  logic                  res_load;
  logic                  wave_done;
  rsp_t                  hold;
  logic                  hold_valid;
  logic                  out_free;

  logic [DATA_WIDTH-1:0] ent [DEPTH];
  wave_t                 wave [DEPTH+1];

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  assign acc        = req_valid && !req_stall;
  assign wr_value   = DATA_WIDTH'(req.value);
  assign cnt8       = 8'(cnt);
  assign cnt9       = 9'(cnt);
  assign full       = (cnt == CW'(DEPTH));
  assign empty      = (cnt == '0);
  assign pos_ok     = (req.position != 8'd0) && (req.position <= cnt8);
  assign pos_ok_ins = (req.position != 8'd0) && (9'(req.position) <= cnt9 + 9'd1);
  assign pos_idx    = req.position - 8'd1;

  // Immediate answer and row command; count, find and a valid get go to the wave
  always_comb begin
    imm_res        = '0;
    imm_res.status = ST_OK;
    cnt_next       = cnt;
    is_scan        = 1'b0;
    ctl.op         = CELL_HOLD;
    ctl.idx        = 8'd0;
    case (req.func)
      FN_INS_HEAD: begin
        if (full) begin
          imm_res.status = ST_FULL;
        end else begin
          ctl.op   = CELL_INS;
          ctl.idx  = 8'd0;
          cnt_next = cnt + CW'(1);
        end
      end
      FN_INS_TAIL: begin
        if (full) begin
          imm_res.status = ST_FULL;
        end else begin
          ctl.op   = CELL_INS;
          ctl.idx  = cnt8;
          cnt_next = cnt + CW'(1);
        end
      end
      FN_INS_POS: begin
        if (!pos_ok_ins) begin
          imm_res.status = ST_BAD_POS;
        end else if (full) begin
          imm_res.status = ST_FULL;
        end else begin
          ctl.op   = CELL_INS;
          ctl.idx  = pos_idx;
          cnt_next = cnt + CW'(1);
        end
      end
      FN_DEL_HEAD: begin
        if (empty) begin
          imm_res.status = ST_EMPTY;
        end else begin
          ctl.op   = CELL_DEL;
          ctl.idx  = 8'd0;
          cnt_next = cnt - CW'(1);
        end
      end
      FN_DEL_TAIL: begin
        if (empty) begin
          imm_res.status = ST_EMPTY;
        end else begin
          ctl.op   = CELL_DEL;
          ctl.idx  = cnt8 - 8'd1;
          cnt_next = cnt - CW'(1);
        end
      end
      FN_DEL_POS: begin
        if (empty) begin
          imm_res.status = ST_EMPTY;
        end else if (!pos_ok) begin
          imm_res.status = ST_BAD_POS;
        end else begin
          ctl.op   = CELL_DEL;
          ctl.idx  = pos_idx;
          cnt_next = cnt - CW'(1);
        end
      end
      FN_COUNT: begin
        is_scan = 1'b1;
      end
      FN_SET: begin
        if (!pos_ok) begin
          imm_res.status = ST_BAD_POS;
        end else begin
          ctl.op  = CELL_WRITE;
          ctl.idx = pos_idx;
        end
      end
      FN_GET: begin
        if (!pos_ok) begin
          imm_res.status = ST_BAD_POS;
        end else begin
          is_scan = 1'b1;
        end
      end
      FN_FIND: begin
        is_scan = 1'b1;
      end
      default: begin
        imm_res.status = ST_OK;
      end
    endcase
    imm_res.length = 8'(cnt_next);
    // Only change the row on an accepted word
    if (!acc) begin
      ctl.op = CELL_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      launch <= 1'b0;
    end else begin
      launch <= acc && is_scan;
      if (acc) begin
        cnt <= cnt_next;
      end
    end
  end

  // Query operands hold still for the whole wave
  always_ff @(posedge clk) begin
    if (acc) begin
      qval  <= wr_value;
      qidx  <= pos_idx;
      qfunc <= req.func;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc && is_scan) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (wave_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    unique case (state)
      S_IDLE:  req_stall = hold_valid;
      S_SCAN:  req_stall = 1'b1;
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell row: entries shift sideways, the query wave runs head to tail
  // ---------------------------------------------------------------------------
  assign wave[0] = '{valid: launch, cnt: 8'd0, fpos: 8'd0, rd: 32'd0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_val;
    logic [DATA_WIDTH-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = wr_value;
    end else begin : g_mid_l
      assign left_val = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val = wr_value;
    end else begin : g_mid_r
      assign right_val = ent[i+1];
    end

    pls_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .wr_value (wr_value),
      .left     (left_val),
      .right    (right_val),
      .entry    (ent[i]),
      .count    (cnt8),
      .qval     (qval),
      .qidx     (qidx),
      .wave_in  (wave[i]),
      .wave_out (wave[i+1])
    );
  end

  assign wave_done = wave[DEPTH].valid;

  // Turn the wave leaving the tail into a result word
  always_comb begin
    scan_res        = '0;
    scan_res.status = ST_OK;
    scan_res.length = cnt8;
    case (qfunc)
      FN_COUNT: begin
        scan_res.match_count = wave[DEPTH].cnt;
      end
      FN_FIND: begin
        if (wave[DEPTH].fpos == 8'd0) begin
          scan_res.status = ST_NOT_FOUND;
        end else begin
          scan_res.found_position = wave[DEPTH].fpos;
        end
      end
      FN_GET: begin
        scan_res.read_value = wave[DEPTH].rd;
      end
      default: begin
        scan_res.status = ST_OK;
      end
    endcase
  end

  assign res_load = wave_done || (acc && !is_scan);
  assign res      = wave_done ? scan_res : imm_res;

  // ---------------------------------------------------------------------------
  // Result buffer: output register backed by one holding register
  // ---------------------------------------------------------------------------
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      if (hold_valid) begin
        rsp_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end else begin
        rsp_valid <= res_load;
      end
    end else if (res_load) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      rsp <= hold_valid ? hold : res;
    end else if (res_load) begin
      hold <= res;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_launch_in_scan: assert property (@(posedge clk) disable iff (rst)
    launch |-> state == S_SCAN)
    else $error("query wave launched outside a scan");

  a_wave_end_clean: assert property (@(posedge clk) disable iff (rst)
    wave_done |-> (state == S_SCAN) && !hold_valid)
    else $error("wave finished with no scan pending or a held word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> rsp_valid)
    else $error("held word with empty output register");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(hold_valid) |-> $past(rsp_valid && rsp_stall))
    else $error("holding register filled while output was free");

endmodule

`default_nettype wire
